// ===== rtl/core/pfb_pkg.sv =====
`default_nettype none

package pfb_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_FLUSH = 2'd2,
    REQ_SENT  = 2'd3
  } req_code_t;

  // Flush engine phase; the fourth code means nothing and acts as idle.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Sequencer states around the frame store.
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_PIXEL = 2'd2,
    ST_FETCH = 2'd3
  } seq_state_t;

  localparam logic [3:0] CMD_COUNT      = 4'd8;
  localparam logic [7:0] CMD_ADDR_MODE  = 8'h20;
  localparam logic [7:0] CMD_COL_RANGE  = 8'h21;
  localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;
  localparam logic [7:0] PIXEL_MSB_MASK = 8'h80;

  // Addressing command sequence sent at the start of a flush.
  function automatic logic [7:0] cmd_byte(input logic [2:0] idx,
                                          input logic [7:0] col_last,
                                          input logic [7:0] page_last);
    logic [7:0] b;
    case (idx)
      3'd0: b = CMD_ADDR_MODE;
      3'd1: b = 8'h00;
      3'd2: b = CMD_COL_RANGE;
      3'd3: b = 8'h00;
      3'd4: b = col_last;
      3'd5: b = CMD_PAGE_RANGE;
      3'd6: b = 8'h00;
      3'd7: b = page_last;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pfb_req_if.sv =====
`default_nettype none

interface pfb_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic               color;

  modport source (output valid, output req_type, output x, output y, output color,
                  input ready);
  modport sink (input valid, input req_type, input x, input y, input color,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pfb_res_if.sv =====
`default_nettype none

interface pfb_res_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] tx_byte;
  logic       is_data;
  logic       link_free;

  modport source (output valid, output byte_valid, output tx_byte, output is_data,
                  output link_free, input ready);
  modport sink (input valid, input byte_valid, input tx_byte, input is_data,
                input link_free, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/page_framebuffer_with_flush.sv =====
`default_nettype none

// An in-range pixel write or a frame data byte first reads the store, then loads
// the result register from that read; every other word loads the result
// register when it is accepted. Words are taken one at a time: a new word is
// taken only when idle and once the previous result has been taken or is taken
// in the same cycle, so directly loaded words can follow back to back while the
// receiver takes them, and none is taken while a pixel write or data byte reads.
// A fill then sweeps every store address. Reset: synchronous; the store is
// cleared by a sweep of all addresses; no word is accepted during either sweep.
module page_framebuffer_with_flush #(
  parameter int COLUMNS    = 128,
  parameter int PAGE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  pfb_req_if.sink     req,
  pfb_res_if.source   res
);

  localparam int STORE  = COLUMNS * PAGE_COUNT;
  localparam int ADDR_W = $clog2(STORE);
  localparam int DIDX_W = $clog2(STORE + 1);
  localparam int XW     = $clog2(COLUMNS);
  localparam logic [7:0] COL_LAST  = 8'(COLUMNS - 1);
  localparam logic [7:0] PAGE_LAST = 8'(PAGE_COUNT - 1);

  pfb_pkg::seq_state_t st, st_next;
  pfb_pkg::phase_t     phase, phase_next;
  logic [3:0]          cmd_idx, cmd_idx_next;
  logic [DIDX_W-1:0]   didx, didx_next;
  logic                free_flag, free_next;
  logic                fill_val, fill_next;
  logic [ADDR_W-1:0]   clr_addr, clr_next;

  logic [ADDR_W-1:0]   pix_addr;
  logic [7:0]          pix_mask;
  logic                pix_color;

  logic [7:0]          mem [STORE];
  logic [7:0]          rd_data;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_wa, mem_ra;
  logic [7:0]          mem_wd;

  logic                res_valid;
  logic                ob_valid, ob_data, ob_free;
  logic [7:0]          ob_byte;
  logic                out_load;

  logic                accept;
  logic                x_ok, y_ok, pix_ok;
  logic [2:0]          pix_row;
  logic [ADDR_W-1:0]   pix_addr_c;
  logic                data_end, data_go, cmd_to_data;
  pfb_pkg::req_code_t  code;

  assign req.ready = (st == pfb_pkg::ST_IDLE) && (!res_valid || res.ready);
  assign accept    = req.valid && req.ready;
  assign code      = pfb_pkg::req_code_t'(req.req_type);

  assign x_ok   = !req.x[15] && (req.x[14:0] < 15'(COLUMNS));
  assign y_ok   = !req.y[15] && (req.y[14:0] < 15'(8 * PAGE_COUNT));
  assign pix_ok = x_ok && y_ok;
  // Page p lives in store row PAGE_COUNT-1-p.
  assign pix_row    = 3'(PAGE_COUNT - 1) - req.y[5:3];
  assign pix_addr_c = ADDR_W'(pix_row) * ADDR_W'(COLUMNS) + ADDR_W'(req.x[XW-1:0]);

  assign data_end    = didx >= DIDX_W'(STORE);
  assign data_go     = (phase == pfb_pkg::PH_DATA) && !data_end && (didx != '0);
  assign cmd_to_data = (phase == pfb_pkg::PH_CMD) && (cmd_idx >= pfb_pkg::CMD_COUNT);

  always_comb begin
    st_next = st;
    case (st)
      pfb_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(STORE - 1)) st_next = pfb_pkg::ST_IDLE;
      end
      pfb_pkg::ST_IDLE: begin
        if (accept) begin
          case (code)
            pfb_pkg::REQ_PIXEL: if (pix_ok) st_next = pfb_pkg::ST_PIXEL;
            pfb_pkg::REQ_FILL:  st_next = pfb_pkg::ST_CLEAR;
            pfb_pkg::REQ_SENT:  if (data_go || cmd_to_data) st_next = pfb_pkg::ST_FETCH;
            default:            st_next = pfb_pkg::ST_IDLE;
          endcase
        end
      end
      default: st_next = pfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we       = 1'b0;
    mem_wa       = clr_addr;
    mem_wd       = {8{fill_val}};
    mem_ra       = '0;
    out_load     = 1'b0;
    ob_valid     = 1'b0;
    ob_byte      = 8'h00;
    ob_data      = 1'b0;
    ob_free      = free_flag;
    phase_next   = phase;
    cmd_idx_next = cmd_idx;
    didx_next    = didx;
    free_next    = free_flag;
    fill_next    = fill_val;
    clr_next     = clr_addr;
    case (st)
      pfb_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        clr_next = clr_addr + ADDR_W'(1);
      end
      pfb_pkg::ST_PIXEL: begin
        mem_we   = 1'b1;
        mem_wa   = pix_addr;
        mem_wd   = pix_color ? (rd_data | pix_mask) : (rd_data & ~pix_mask);
        out_load = 1'b1;
      end
      pfb_pkg::ST_FETCH: begin
        out_load = 1'b1;
        ob_valid = 1'b1;
        ob_byte  = rd_data;
        ob_data  = 1'b1;
      end
      default: begin
        if (accept) begin
          case (code)
            pfb_pkg::REQ_PIXEL: begin
              if (pix_ok) mem_ra = pix_addr_c;
              else out_load = 1'b1;
            end
            pfb_pkg::REQ_FILL: begin
              fill_next = req.color;
              clr_next  = '0;
              out_load  = 1'b1;
            end
            pfb_pkg::REQ_FLUSH: begin
              phase_next   = pfb_pkg::PH_CMD;
              didx_next    = '0;
              cmd_idx_next = 4'd1;
              free_next    = 1'b0;
              out_load     = 1'b1;
              ob_valid     = 1'b1;
              ob_byte      = pfb_pkg::cmd_byte(3'd0, COL_LAST, PAGE_LAST);
              ob_free      = 1'b0;
            end
            default: begin
              case (phase)
                pfb_pkg::PH_DATA: begin
                  if (data_end) begin
                    didx_next  = '0;
                    phase_next = pfb_pkg::PH_IDLE;
                    free_next  = 1'b1;
                    out_load   = 1'b1;
                    ob_free    = 1'b1;
                  end else if (didx != '0) begin
                    mem_ra    = didx[ADDR_W-1:0];
                    didx_next = didx + DIDX_W'(1);
                  end else begin
                    out_load = 1'b1;
                  end
                end
                pfb_pkg::PH_CMD: begin
                  if (cmd_to_data) begin
                    phase_next = pfb_pkg::PH_DATA;
                    mem_ra     = '0;
                    didx_next  = DIDX_W'(1);
                  end else begin
                    out_load     = 1'b1;
                    ob_valid     = 1'b1;
                    ob_byte      = pfb_pkg::cmd_byte(cmd_idx[2:0], COL_LAST, PAGE_LAST);
                    cmd_idx_next = cmd_idx + 4'd1;
                  end
                end
                default: begin
                  phase_next = pfb_pkg::PH_IDLE;
                  free_next  = 1'b1;
                  out_load   = 1'b1;
                  ob_free    = 1'b1;
                end
              endcase
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= pfb_pkg::ST_CLEAR;
      phase     <= pfb_pkg::PH_IDLE;
      cmd_idx   <= '0;
      didx      <= '0;
      free_flag <= 1'b1;
      fill_val  <= 1'b0;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      st        <= st_next;
      phase     <= phase_next;
      cmd_idx   <= cmd_idx_next;
      didx      <= didx_next;
      free_flag <= free_next;
      fill_val  <= fill_next;
      clr_addr  <= clr_next;
      if (out_load) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_addr  <= pix_addr_c;
      pix_mask  <= pfb_pkg::PIXEL_MSB_MASK >> req.y[2:0];
      pix_color <= req.color;
    end
    if (out_load) begin
      res.byte_valid <= ob_valid;
      res.tx_byte    <= ob_byte;
      res.is_data    <= ob_data;
      res.link_free  <= ob_free;
    end
  end

  assign res.valid = res_valid;

`ifndef SYNTH
  // A store read is only started when the result register will be free.
  assert property (@(posedge clk) disable iff (rst)
    (st == pfb_pkg::ST_PIXEL || st == pfb_pkg::ST_FETCH) |-> !res_valid)
    else $error("store read finishing while a result is still pending");

  // The link is free exactly when no flush is in progress.
  assert property (@(posedge clk) disable iff (rst)
    free_flag == (phase == pfb_pkg::PH_IDLE))
    else $error("free flag disagrees with flush phase");

  // Frame data fetches only happen in the data phase.
  assert property (@(posedge clk) disable iff (rst)
    (st == pfb_pkg::ST_FETCH) |-> (phase == pfb_pkg::PH_DATA))
    else $error("frame fetch outside the data phase");

  // A data byte is always a real byte on the link.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.is_data) |-> res.byte_valid)
    else $error("data flag set on an empty result");

  // The flush engine holds still while the store is being swept.
  assert property (@(posedge clk) disable iff (rst)
    (st == pfb_pkg::ST_CLEAR) |=> $stable(phase) && $stable(didx))
    else $error("flush state changed during a store sweep");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pfb_pkg::*;

  localparam int COLUMNS     = 128;
  localparam int PAGE_COUNT  = 8;
  localparam int STORE_BYTES = COLUMNS * PAGE_COUNT;
  localparam int PIXEL_ROWS  = 8 * PAGE_COUNT;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  // Addressing commands of a flush, first command in the top byte.
  localparam logic [63:0] ADDR_SEQ = {CMD_ADDR_MODE, 8'h00, CMD_COL_RANGE, 8'h00,
                                      8'(COLUMNS - 1), CMD_PAGE_RANGE, 8'h00,
                                      8'(PAGE_COUNT - 1)};

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       is_data;
    logic       link_free;
  } link_word_t;

  typedef struct {
    req_code_t          kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               lit;
    bit                 typed;
    link_word_t         want;
  } dir_row_t;

  logic clk;
  logic rst;

  pfb_req_if req_bus ();
  pfb_res_if res_bus ();

  page_framebuffer_with_flush #(
    .COLUMNS    (COLUMNS),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .res (res_bus)
  );

  // Shadow copy of the frame store and of the flush engine.
  logic [7:0] shadow_fb [STORE_BYTES];
  phase_t     flush_phase;
  logic [3:0] cmd_pos;
  int         data_pos;
  logic       link_free_flag;

  link_word_t expected_link_q [$];
  dir_row_t   dir_rows [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         sender_idle_pct;
  int         recv_stall_pct;
  int         hold_asks;
  int         hold_seen = 0;
  int         hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic link_word_t word(int bv, logic [7:0] tx, int dat, int free);
    link_word_t w;
    w.byte_valid = 1'(bv);
    w.tx_byte    = tx;
    w.is_data    = 1'(dat);
    w.link_free  = 1'(free);
    return w;
  endfunction

  function automatic link_word_t predict_link_word(req_code_t kind, logic signed [15:0] px,
                                                   logic signed [15:0] py, logic lit);
    link_word_t w;
    int xi;
    int yi;
    int addr;
    w  = '0;
    xi = int'(px);
    yi = int'(py);
    case (kind)
      REQ_PIXEL: begin
        if (xi >= 0 && yi >= 0 && xi < COLUMNS && yi < PIXEL_ROWS) begin
          // Page p is kept in store row PAGE_COUNT-1-p, bit 7 is the top pixel.
          addr = (PAGE_COUNT - 1 - yi / 8) * COLUMNS + xi;
          if (lit)
            shadow_fb[addr] = shadow_fb[addr] | (PIXEL_MSB_MASK >> (yi % 8));
          else
            shadow_fb[addr] = shadow_fb[addr] & ~(PIXEL_MSB_MASK >> (yi % 8));
        end
      end
      REQ_FILL: begin
        foreach (shadow_fb[i]) shadow_fb[i] = lit ? 8'hFF : 8'h00;
      end
      REQ_FLUSH: begin
        flush_phase    = PH_CMD;
        data_pos       = 0;
        cmd_pos        = 4'd1;
        link_free_flag = 1'b0;
        w.byte_valid   = 1'b1;
        w.tx_byte      = ADDR_SEQ[63 -: 8];
      end
      default: begin
        if (flush_phase == PH_DATA) begin
          if (data_pos >= STORE_BYTES) begin
            data_pos       = 0;
            flush_phase    = PH_IDLE;
            link_free_flag = 1'b1;
          end else if (data_pos != 0) begin
            w.byte_valid = 1'b1;
            w.is_data    = 1'b1;
            w.tx_byte    = shadow_fb[data_pos];
            data_pos++;
          end
        end else if (flush_phase == PH_CMD) begin
          if (cmd_pos >= CMD_COUNT) begin
            flush_phase  = PH_DATA;
            w.byte_valid = 1'b1;
            w.is_data    = 1'b1;
            w.tx_byte    = shadow_fb[0];
            data_pos     = 1;
          end else begin
            w.byte_valid = 1'b1;
            w.tx_byte    = ADDR_SEQ[63 - 8 * cmd_pos -: 8];
            cmd_pos++;
          end
        end else begin
          flush_phase    = PH_IDLE;
          link_free_flag = 1'b1;
        end
      end
    endcase
    w.link_free = link_free_flag;
    return w;
  endfunction

  task automatic send_request(input req_code_t kind, input logic signed [15:0] px,
                              input logic signed [15:0] py, input logic lit,
                              input bit typed, input link_word_t want);
    link_word_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid    = 1'b1;
    req_bus.req_type = kind;
    req_bus.x        = px;
    req_bus.y        = py;
    req_bus.color    = lit;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predicted = predict_link_word(kind, px, py, lit);
    expected_link_q.push_back(typed ? want : predicted);
  endtask

  task automatic send_pixel(input bit on_screen);
    logic signed [15:0] px;
    logic signed [15:0] py;
    px = 16'($urandom_range(COLUMNS - 1));
    py = 16'($urandom_range(PIXEL_ROWS - 1));
    if (!on_screen) begin
      case ($urandom_range(4))
        0: px = 16'(-$urandom_range(32768, 1));
        1: py = 16'(-$urandom_range(32768, 1));
        2: px = 16'($urandom_range(32767, COLUMNS));
        3: py = 16'($urandom_range(32767, PIXEL_ROWS));
        default: begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
      endcase
    end
    send_request(REQ_PIXEL, px, py, 1'($urandom_range(1)), 1'b0, '0);
  endtask

  task automatic send_mix(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_request(REQ_SENT, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                     1'b0, '0);
      else if (pick < 80)
        send_pixel(1'b1);
      else if (pick < 96)
        send_pixel(1'b0);
      else if (pick < 99)
        send_request(REQ_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                     1'b0, '0);
      else
        send_request(REQ_FILL, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                     1'b0, '0);
    end
  endtask

  // A flush walked to its end, with drawing mixed in while bytes go out.
  task automatic send_full_flush();
    int pick;
    send_request(REQ_FLUSH, 16'($urandom), 16'($urandom), 1'($urandom_range(1)), 1'b0, '0);
    while (flush_phase != PH_IDLE) begin
      pick = $urandom_range(999);
      if (pick < 880)
        send_request(REQ_SENT, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                     1'b0, '0);
      else if (pick < 996)
        send_pixel(1'b1);
      else
        send_request(REQ_FILL, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                     1'b0, '0);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    req_bus.valid = 1'b0;
    wait (expected_link_q.size() == 0);
  endtask

  function automatic void add_row(req_code_t kind, int px, int py, int lit,
                                  int typed, link_word_t want);
    dir_row_t r;
    r.kind  = kind;
    r.px    = 16'(px);
    r.py    = 16'(py);
    r.lit   = 1'(lit);
    r.typed = 1'(typed);
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  // Receiver: random stalls, plus a long hold-off when the stimulus asks.
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready = 1'b0;
    end else begin
      res_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    link_word_t exp_w;
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      if (expected_link_q.size() == 0) begin
        $error("link word with no request pending: tx_byte %0h", res_bus.tx_byte);
        fail_count++;
      end else begin
        exp_w = expected_link_q.pop_front();
        if (res_bus.byte_valid !== exp_w.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", exp_w.byte_valid, res_bus.byte_valid);
          fail_count++;
        end
        if (res_bus.tx_byte !== exp_w.tx_byte) begin
          $error("tx_byte: expected %0h, got %0h", exp_w.tx_byte, res_bus.tx_byte);
          fail_count++;
        end
        if (res_bus.is_data !== exp_w.is_data) begin
          $error("is_data: expected %0d, got %0d", exp_w.is_data, res_bus.is_data);
          fail_count++;
        end
        if (res_bus.link_free !== exp_w.link_free) begin
          $error("link_free: expected %0d, got %0d", exp_w.link_free, res_bus.link_free);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("page_framebuffer_with_flush test failed");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_PIXEL;
    req_bus.x        = '0;
    req_bus.y        = '0;
    req_bus.color    = 1'b0;
    foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
    flush_phase      = PH_IDLE;
    cmd_pos          = 4'd0;
    data_pos         = 0;
    link_free_flag   = 1'b1;
    hold_asks        = 0;
    sender_idle_pct  = 11;
    recv_stall_pct   = 53;

    // Corners of the screen, off-screen writes, two fills, and a flush restarted
    // partway through its commands.
    add_row(REQ_SENT,  0,      0,     1, 1, word(0, 8'h00, 0, 1));
    add_row(REQ_PIXEL, 0,      0,     1, 1, word(0, 8'h00, 0, 1));
    add_row(REQ_PIXEL, 127,    63,    1, 0, '0);
    add_row(REQ_PIXEL, -1,     0,     1, 0, '0);
    add_row(REQ_PIXEL, 0,      -1,    1, 0, '0);
    add_row(REQ_PIXEL, 128,    5,     1, 0, '0);
    add_row(REQ_PIXEL, 5,      64,    1, 0, '0);
    add_row(REQ_PIXEL, -32768, 32767, 1, 0, '0);
    add_row(REQ_PIXEL, 32767,  -32768, 1, 0, '0);
    add_row(REQ_PIXEL, 0,      0,     0, 0, '0);
    add_row(REQ_PIXEL, 0,      7,     1, 0, '0);
    add_row(REQ_FILL,  -1,     -1,    1, 1, word(0, 8'h00, 0, 1));
    add_row(REQ_PIXEL, 3,      9,     0, 0, '0);
    add_row(REQ_FLUSH, 0,      0,     0, 1, word(1, CMD_ADDR_MODE, 0, 0));
    add_row(REQ_SENT,  0,      0,     0, 1, word(1, 8'h00, 0, 0));
    add_row(REQ_SENT,  0,      0,     0, 1, word(1, CMD_COL_RANGE, 0, 0));
    add_row(REQ_FLUSH, -1,     -1,    1, 1, word(1, CMD_ADDR_MODE, 0, 0));
    for (int i = 0; i < 4; i++) add_row(REQ_SENT, 0, 0, 0, 0, '0);
    add_row(REQ_PIXEL, 0,      63,    0, 0, '0);
    for (int i = 0; i < 3; i++) add_row(REQ_SENT, 0, 0, 0, 0, '0);
    add_row(REQ_SENT,  0,      0,     0, 0, '0);
    add_row(REQ_FILL,  0,      0,     0, 1, word(0, 8'h00, 0, 0));
    add_row(REQ_SENT,  0,      0,     0, 0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].px, dir_rows[i].py, dir_rows[i].lit,
                   dir_rows[i].typed, dir_rows[i].want);

    send_mix(250);
    // The sink stops taking words for a while so the block backs up.
    hold_asks++;
    send_mix(60);
    drain();
    send_full_flush();
    send_request(REQ_SENT, 16'($urandom), 16'($urandom), 1'($urandom_range(1)), 1'b0, '0);

    sender_idle_pct = 53;
    recv_stall_pct  = 11;
    send_mix(250);
    drain();

    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_mix(200);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("page_framebuffer_with_flush test passed");
    else
      $display("page_framebuffer_with_flush test failed");
    $finish;
  end

endmodule
